FILE: rtl/ste_pkg.sv
// package of shared types and constants for the synaptic trace engine
package ste_pkg;

	localparam int unsigned ACT_W = 3;
	localparam logic [ACT_W-1:0] ACT_CLEAR   = 3'd0;
	localparam logic [ACT_W-1:0] ACT_LOAD    = 3'd1;
	localparam logic [ACT_W-1:0] ACT_SPIKE   = 3'd2;
	localparam logic [ACT_W-1:0] ACT_ADVANCE = 3'd3;
	localparam logic [ACT_W-1:0] ACT_READ    = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_ORDER = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	localparam int unsigned IDX_W = 6;
	localparam int unsigned VAL_W = 16;
	localparam int unsigned SUM_W = 48;
	localparam int unsigned CNT_W = 7;
	localparam logic [VAL_W-1:0] ONE_Q15 = 16'h8000;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_FILL,
		S_WALK,
		S_DRAIN,
		S_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic fill_step;
		logic walk_start;
		logic walk_step;
		logic drain_step;
		logic out_load;
		logic out_take;
	} cmd_t;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic             fill_more;
		logic             walk_more;
		logic             pipe_empty;
		logic             out_full;
	} stat_t;

endpackage

FILE: rtl/ste_ctrl.sv
// controller state machine for the synaptic trace engine
module ste_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_fire,
	input  logic            out_fire,
	input  ste_pkg::stat_t  stat,
	output ste_pkg::cmd_t   cmd,
	output logic            busy
);

	ste_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ste_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ste_pkg::S_IDLE: begin
				if (in_fire) state_d = ste_pkg::S_EXEC;
			end
			ste_pkg::S_EXEC: begin
				if (stat.action == ste_pkg::ACT_LOAD && stat.fill_more) begin
					state_d = ste_pkg::S_FILL;
				end else if (stat.action == ste_pkg::ACT_ADVANCE ||
				             stat.action == ste_pkg::ACT_READ) begin
					state_d = ste_pkg::S_WALK;
				end else begin
					state_d = ste_pkg::S_OUT;
				end
			end
			ste_pkg::S_FILL: begin
				if (!stat.fill_more) state_d = ste_pkg::S_OUT;
			end
			ste_pkg::S_WALK: begin
				if (!stat.walk_more) state_d = ste_pkg::S_DRAIN;
			end
			ste_pkg::S_DRAIN: begin
				if (stat.pipe_empty) state_d = ste_pkg::S_OUT;
			end
			ste_pkg::S_OUT: begin
				if (!stat.out_full || out_fire) state_d = ste_pkg::S_IDLE;
			end
			default: state_d = ste_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = (state_q != ste_pkg::S_IDLE);
		case (state_q)
			ste_pkg::S_IDLE: cmd.start = in_fire;
			ste_pkg::S_EXEC: cmd.walk_start = 1'b1;
			ste_pkg::S_FILL: cmd.fill_step = 1'b1;
			ste_pkg::S_WALK: cmd.walk_step = 1'b1;
			ste_pkg::S_DRAIN: cmd.drain_step = 1'b1;
			ste_pkg::S_OUT: cmd.out_load = !stat.out_full || out_fire;
			default: cmd = '0;
		endcase
		cmd.out_take = out_fire;
	end

endmodule

FILE: rtl/ste_datapath.sv
// datapath of the synaptic trace engine: edge memories, row table, trace arithmetic
module ste_datapath #(
	parameter int unsigned MAX_NEURONS = 64,
	parameter int unsigned MAX_EDGES   = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ste_pkg::CNT_W-1:0]     cfg_data,
	input  ste_pkg::cmd_t                 cmd,
	input  logic [ste_pkg::ACT_W-1:0]     in_action,
	input  logic [ste_pkg::IDX_W-1:0]     in_row,
	input  logic [ste_pkg::IDX_W-1:0]     in_col,
	input  logic [ste_pkg::VAL_W-1:0]     in_weight,
	input  logic [ste_pkg::VAL_W-1:0]     in_decay,
	input  logic [ste_pkg::VAL_W-1:0]     in_spike,
	output ste_pkg::stat_t                stat,
	output logic                          out_valid,
	output logic [1:0]                    out_status,
	output logic signed [ste_pkg::SUM_W-1:0] out_sum
);

	localparam int unsigned EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int unsigned EC_W = $clog2(MAX_EDGES + 1);
	localparam int unsigned RT_D = (MAX_NEURONS < 64 ? MAX_NEURONS : 64) + 1;
	localparam int unsigned RT_W = $clog2(RT_D);
	localparam int unsigned NB_W = $clog2(MAX_NEURONS + 1);
	localparam int unsigned SP_D = (MAX_NEURONS < 64) ? MAX_NEURONS : 64;
	localparam int unsigned SP_W = $clog2(SP_D);
	localparam logic [EC_W-1:0] EDGE_MAX = EC_W'(MAX_EDGES);
	localparam logic [NB_W-1:0] NMAX = NB_W'(MAX_NEURONS);

	logic [ste_pkg::ACT_W-1:0] act_q;
	logic [ste_pkg::IDX_W-1:0] row_q, col_q;
	logic [ste_pkg::VAL_W-1:0] wgt_q, dec_q, spk_q;
	logic [ste_pkg::CNT_W-1:0] ncount_q;
	logic [EC_W-1:0] total_q;
	logic [ste_pkg::IDX_W-1:0] crow_q;
	logic [ste_pkg::IDX_W:0] fill_q;
	logic [EC_W-1:0] row_start_mem [RT_D];
	logic [EC_W-1:0] rs_lo_q, rs_hi_q;
	logic [ste_pkg::VAL_W-1:0] spike_q [SP_D];
	logic [1:0] status_q;

	logic [ste_pkg::VAL_W-1:0] weight_mem [MAX_EDGES];
	logic [ste_pkg::VAL_W-1:0] decay_mem  [MAX_EDGES];
	logic [ste_pkg::VAL_W-1:0] trace_mem  [MAX_EDGES];
	logic [ste_pkg::IDX_W-1:0] column_mem [MAX_EDGES];

	logic [EC_W-1:0] k_q, end_q;
	logic v_s1, v_s2, v_s3;
	logic [EA_W-1:0] a_s1, a_s2, a_s3;
	logic [ste_pkg::VAL_W-1:0] w_s1, d_s1, t_s1;
	logic [ste_pkg::VAL_W-1:0] w_s2, d_s2, t_s2, sp_s2;
	logic [ste_pkg::IDX_W-1:0] c_s1;
	logic signed [31:0] prod_s3;
	logic [ste_pkg::VAL_W-1:0] s_s3;
	logic signed [ste_pkg::SUM_W-1:0] acc_q;

	logic [NB_W-1:0] nact;
	logic row_ok, col_ok;
	logic [1:0] chk_status;

	always_comb begin
		nact = (NB_W'(ncount_q) < NMAX) ? NB_W'(ncount_q) : NMAX;
		row_ok = NB_W'(row_q) < nact;
		col_ok = NB_W'(col_q) < nact;
		chk_status = ste_pkg::ST_OK;
		case (act_q)
			ste_pkg::ACT_LOAD: begin
				if (!row_ok || !col_ok) chk_status = ste_pkg::ST_RANGE;
				else if (row_q < crow_q) chk_status = ste_pkg::ST_ORDER;
				else if (total_q >= EDGE_MAX) chk_status = ste_pkg::ST_FULL;
			end
			ste_pkg::ACT_SPIKE: if (!col_ok) chk_status = ste_pkg::ST_RANGE;
			ste_pkg::ACT_READ: if (!row_ok) chk_status = ste_pkg::ST_RANGE;
			default: chk_status = ste_pkg::ST_OK;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			act_q <= in_action;
			row_q <= in_row;
			col_q <= in_col;
			wgt_q <= in_weight;
			dec_q <= in_decay;
			spk_q <= (in_spike > ste_pkg::ONE_Q15) ? ste_pkg::ONE_Q15 : in_spike;
		end
	end

	logic load_ok;
	assign load_ok = cmd.walk_start && act_q == ste_pkg::ACT_LOAD &&
	                 chk_status == ste_pkg::ST_OK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ncount_q <= ste_pkg::CNT_W'(64);
			total_q <= '0;
			crow_q <= '0;
			fill_q <= '0;
			status_q <= ste_pkg::ST_OK;
			for (int i = 0; i < SP_D; i++) spike_q[i] <= '0;
		end else begin
			if (cfg_we) ncount_q <= cfg_data;
			if (cmd.walk_start) begin
				status_q <= chk_status;
				case (act_q)
					ste_pkg::ACT_CLEAR: begin
						total_q <= '0;
						crow_q <= '0;
					end
					ste_pkg::ACT_LOAD: begin
						if (chk_status == ste_pkg::ST_OK) begin
							fill_q <= {1'b0, crow_q} + 1'b1;
						end
					end
					ste_pkg::ACT_SPIKE: begin
						if (chk_status == ste_pkg::ST_OK) spike_q[col_q[SP_W-1:0]] <= spk_q;
					end
					default: ;
				endcase
			end
			if (cmd.fill_step) begin
				if (fill_q <= {1'b0, row_q}) begin
					fill_q <= fill_q + 1'b1;
				end else begin
					crow_q <= row_q;
					total_q <= total_q + 1'b1;
				end
			end
		end
	end

	// row start table, entry 0 is never stored; row 0 is taken to start at zero
	always_ff @(posedge clk) begin
		if (cmd.fill_step && fill_q <= {1'b0, row_q}) begin
			row_start_mem[RT_W'(fill_q)] <= total_q;
		end
		if (cmd.start) begin
			rs_lo_q <= row_start_mem[RT_W'(in_row)];
			rs_hi_q <= row_start_mem[RT_W'(in_row) + RT_W'(1)];
		end
	end

	always_ff @(posedge clk) begin
		if (load_ok) begin
			weight_mem[total_q[EA_W-1:0]] <= wgt_q;
			decay_mem[total_q[EA_W-1:0]] <= dec_q;
			column_mem[total_q[EA_W-1:0]] <= col_q;
		end
	end

	// walk bounds
	logic [EC_W-1:0] w_start, w_end;
	always_comb begin
		if (act_q == ste_pkg::ACT_ADVANCE) begin
			w_start = '0;
			w_end = total_q;
		end else if (chk_status != ste_pkg::ST_OK) begin
			w_start = '0;
			w_end = '0;
		end else begin
			if (row_q <= crow_q) w_start = (row_q == '0) ? '0 : rs_lo_q;
			else w_start = total_q;
			w_end = (row_q < crow_q) ? rs_hi_q : total_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
			end_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (cmd.walk_start) begin
				k_q <= w_start;
				end_q <= w_end;
			end else if (cmd.walk_step && k_q < end_q) begin
				k_q <= k_q + 1'b1;
			end
			v_s1 <= cmd.walk_step && k_q < end_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign stat.walk_more = (k_q + 1'b1) < end_q;

	// stage 1: memory reads
	always_ff @(posedge clk) begin
		a_s1 <= k_q[EA_W-1:0];
		w_s1 <= weight_mem[k_q[EA_W-1:0]];
		d_s1 <= decay_mem[k_q[EA_W-1:0]];
		t_s1 <= trace_mem[k_q[EA_W-1:0]];
		c_s1 <= column_mem[k_q[EA_W-1:0]];
	end

	// stage 2: spike buffer read
	always_ff @(posedge clk) begin
		a_s2 <= a_s1;
		w_s2 <= w_s1;
		d_s2 <= d_s1;
		t_s2 <= t_s1;
		sp_s2 <= (NB_W'(c_s1) < NMAX) ? spike_q[c_s1[SP_W-1:0]] : '0;
	end

	// stage 3: one multiply
	logic signed [17:0] diff;
	assign diff = $signed({2'b00, t_s2}) - $signed({2'b00, sp_s2});

	always_ff @(posedge clk) begin
		a_s3 <= a_s2;
		s_s3 <= sp_s2;
		if (act_q == ste_pkg::ACT_ADVANCE) begin
			prod_s3 <= 32'($signed({1'b0, d_s2})) * 32'(diff);
		end else begin
			prod_s3 <= 32'($signed(w_s2)) * 32'($signed({1'b0, t_s2}));
		end
	end

	// stage 4: write back or accumulate
	logic signed [ste_pkg::VAL_W+1:0] newt;
	assign newt = $signed({2'b00, s_s3}) + 18'(prod_s3 >>> 16);

	always_ff @(posedge clk) begin
		if (load_ok) begin
			trace_mem[total_q[EA_W-1:0]] <= '0;
		end else if (v_s3 && act_q == ste_pkg::ACT_ADVANCE) begin
			trace_mem[a_s3] <= newt[ste_pkg::VAL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cmd.walk_start) begin
			acc_q <= '0;
		end else if (v_s3 && act_q == ste_pkg::ACT_READ) begin
			acc_q <= acc_q + ste_pkg::SUM_W'(prod_s3);
		end
	end

	assign stat.pipe_empty = !v_s1 && !v_s2 && !v_s3;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (cmd.out_take) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status <= status_q;
			out_sum <= (act_q == ste_pkg::ACT_READ) ? acc_q : '0;
		end
	end

	assign stat.action = act_q;
	assign stat.fill_more = (cmd.walk_start) ? (chk_status == ste_pkg::ST_OK) :
	                        (fill_q <= {1'b0, row_q});
	assign stat.out_full = out_valid;

endmodule

FILE: rtl/synaptic_trace_engine_unit.sv
// top level of the synaptic trace engine
//
// input words arrive on s_axis (tdata: action, row, column, weight, decay,
// spike from the lowest bit up); one result word per input leaves on m_axis
// (tdata: status, row_sum).
// the user must write the neuron count register through cfg_we / cfg_data
// only while idle; the block itself does not enforce this. one word is
// handled at a time; s_axis_tready is high only when idle, so no new word is
// taken while one is being handled. clear, set spike, flagged loads and
// unused actions go from the accepting state straight to the result; a good
// load first fills one row start entry per row it moves the current row
// forward; advance walks every stored edge and read row the edges of its row,
// one address a cycle through the single read port of the edge memories and
// a four-stage pipeline that then drains before the result is loaded.
// while a result waits for the receiver the next word is still taken, then
// the engine holds with its new result until the waiting one is taken.
// reset empties the edge table, zeroes the spike buffer and sets the neuron
// count to 64; the edge memories themselves are not cleared.
module synaptic_trace_engine_unit #(
	parameter int unsigned MAX_NEURONS = 64,
	parameter int unsigned MAX_EDGES   = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // action, row, column, weight, decay, spike
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata   // status, row_sum
);

	ste_pkg::cmd_t cmd;
	ste_pkg::stat_t stat;
	logic busy, in_fire, out_fire;
	logic [1:0] st;
	logic signed [ste_pkg::SUM_W-1:0] sum;

	assign s_axis_tready = !busy;
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign out_fire = m_axis_tvalid && m_axis_tready;
	assign m_axis_tdata = {6'd0, sum, st};

	ste_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_fire(out_fire),
		.stat(stat), .cmd(cmd), .busy(busy)
	);

	ste_datapath #(.MAX_NEURONS(MAX_NEURONS), .MAX_EDGES(MAX_EDGES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.cmd(cmd),
		.in_action(s_axis_tdata[2:0]), .in_row(s_axis_tdata[8:3]),
		.in_col(s_axis_tdata[14:9]), .in_weight(s_axis_tdata[30:15]),
		.in_decay(s_axis_tdata[46:31]), .in_spike(s_axis_tdata[62:47]),
		.stat(stat), .out_valid(m_axis_tvalid), .out_status(st), .out_sum(sum)
	);

endmodule
